// ===== sv/swrb_pkg.sv =====
// types and constants shared by the sliding window reorder buffer
// no dependencies; imported by sliding_window_reorder_buffer
`default_nettype none

package swrb_pkg;

    localparam int SEQ_W      = 31;
    localparam int WORD_W     = 32;
    localparam int MARK_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [SEQ_W-1:0]  SEQ_MAX         = {SEQ_W{1'b1}};
    localparam logic [SEQ_W-1:0]  MAX_SEQ_RESET   = {SEQ_W{1'b1}};
    localparam logic [MARK_W-1:0] HIGH_MARK_RESET = 7'd48;
    localparam logic [MARK_W-1:0] LOW_MARK_RESET  = 7'd16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEQUENCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MARK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_MARK     = 2'd2;

    typedef enum logic [0:0] {
        OP_ADD  = 1'b0,
        OP_NEXT = 1'b1
    } t_op;

    typedef struct packed {
        t_op               operation;
        logic [SEQ_W-1:0]  sequence_req;
        logic [WORD_W-1:0] payload;
    } t_swrb_in;

    typedef struct packed {
        logic              success;
        logic [WORD_W-1:0] out_word;
        logic              high_water;
        logic              low_water;
    } t_swrb_out;

    // one slot of the store: occupancy flag and data word
    typedef struct packed {
        logic              full;
        logic [WORD_W-1:0] word;
    } t_swrb_slot;

endpackage

`default_nettype wire

// ===== sv/sliding_window_reorder_buffer.sv =====
// pipeline: the item is registered with its quotient estimate, the slot memory is read
// with the modulo stage, then the commit writes the output register
// throughput: one add or next per cycle while o_stall is low; the slot memory does one
// read and one write a cycle, with the commit stage forwarding to the read behind it
// reset: synchronous, active low; a clearing pass then empties every slot, during which
// no item is taken (configuration writes still land)
//
// sliding window reorder buffer top level; uses swrb_pkg
`default_nettype none

module sliding_window_reorder_buffer #(
    parameter int DEPTH = 64
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // item channel
    input  wire                              i_valid,
    output logic                             o_stall,
    input  swrb_pkg::t_swrb_in               i_item,
    // result channel
    output logic                             o_valid,
    input  wire                              i_stall,
    output swrb_pkg::t_swrb_out              o_result,
    // configuration write port
    input  wire                              i_cfg_wr_en,
    input  wire [swrb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [swrb_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import swrb_pkg::*;

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // slot index
    localparam int CW   = $clog2(DEPTH + 1);                // entry count
    localparam int RW   = AW + 1;                           // raw remainder, below 2*DEPTH
    localparam int CMPW = (CW > MARK_W) ? CW : MARK_W;
    localparam int PW   = 2 * SEQ_W;
    // reciprocal of DEPTH scaled by 2^31; the quotient estimate is at most one low
    localparam logic [SEQ_W-1:0] RECIP = SEQ_W'((64'd1 << SEQ_W) / DEPTH);
    localparam logic [RW-1:0]    DEPTH_R    = RW'(DEPTH);
    localparam logic [AW-1:0]    LAST_SLOT  = AW'(DEPTH - 1);
    localparam logic [CW-1:0]    DEPTH_C    = CW'(DEPTH);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [SEQ_W-1:0]  r_max_seq;
    logic [MARK_W-1:0] r_high_mark;
    logic [MARK_W-1:0] r_low_mark;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_seq   <= MAX_SEQ_RESET;
            r_high_mark <= HIGH_MARK_RESET;
            r_low_mark  <= LOW_MARK_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MAX_SEQUENCE: r_max_seq   <= i_cfg_wdata[SEQ_W-1:0];
                CFG_HIGH_MARK:    r_high_mark <= i_cfg_wdata[MARK_W-1:0];
                CFG_LOW_MARK:     r_low_mark  <= i_cfg_wdata[MARK_W-1:0];
                default: ;        // unknown index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    logic r_s0_valid, r_s1_valid, r_out_valid;
    logic r_clearing;
    logic out_free, adv1, s1_free, adv0, s0_free, in_xfer;

    always_comb begin
        out_free = !r_out_valid || !i_stall;
        adv1     = r_s1_valid && out_free;
        s1_free  = !r_s1_valid || adv1;
        adv0     = r_s0_valid && s1_free;
        s0_free  = !r_s0_valid || adv0;
        o_stall  = r_clearing || !s0_free;
        in_xfer  = i_valid && !o_stall;
    end

    // ------------------------------------------------------------------
    // stage 0: sequence number modulo DEPTH
    // ------------------------------------------------------------------
    // quotient estimate by reciprocal multiply, registered with the item
    logic [PW-1:0]    in_prod;
    t_swrb_in         r_s0;
    logic [SEQ_W-1:0] r_s0_quot;

    assign in_prod = PW'(i_item.sequence_req) * PW'(RECIP);

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s0      <= i_item;
            r_s0_quot <= in_prod[PW-1:SEQ_W];
        end
    end

    // remainder = seq - q*DEPTH lies in [0, 2*DEPTH): only the low RW bits matter
    logic [2*RW-1:0] qd_full;
    logic [RW-1:0]   rem_raw;
    logic [AW-1:0]   add_slot;

    always_comb begin
        qd_full  = {{RW{1'b0}}, r_s0_quot[RW-1:0]} * {{RW{1'b0}}, DEPTH_R};
        rem_raw  = r_s0.sequence_req[RW-1:0] - qd_full[RW-1:0];
        add_slot = (rem_raw >= DEPTH_R) ? AW'(rem_raw - DEPTH_R) : AW'(rem_raw);
    end

    // ------------------------------------------------------------------
    // window state
    // ------------------------------------------------------------------
    logic [SEQ_W-1:0] r_ws,      n_ws;
    logic [AW-1:0]    r_ws_slot, n_ws_slot;    // window start modulo DEPTH
    logic [CW-1:0]    r_count,   n_count;

    // next reads the slot of the window start as it stands after the commit
    // happening in the same cycle
    logic [AW-1:0] fwd_ws_slot, rd_addr;

    assign fwd_ws_slot = adv1 ? n_ws_slot : r_ws_slot;
    assign rd_addr     = (r_s0.operation == OP_NEXT) ? fwd_ws_slot : add_slot;

    // ------------------------------------------------------------------
    // slot memory: read in stage 0 -> 1 transfer, written at commit
    // ------------------------------------------------------------------
    t_swrb_slot    mem [DEPTH];
    t_swrb_slot    r_rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_swrb_slot    mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv0) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // clearing pass after reset
    logic [AW-1:0] r_clear_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clear_idx <= '0;
        end else if (r_clearing) begin
            r_clear_idx <= r_clear_idx + AW'(1);
            if (r_clear_idx == LAST_SLOT) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: read-modify-write of the slot and the window state
    // ------------------------------------------------------------------
    t_swrb_in      r_s1;
    logic [AW-1:0] r_s1_slot;
    logic          r_byp_hit;
    t_swrb_slot    r_byp_data;

    // write-side slot update from stage 1
    logic          s1_we;
    t_swrb_slot    s1_wdata;

    always_ff @(posedge i_clk) begin
        if (adv0) begin
            r_s1       <= r_s0;
            r_s1_slot  <= rd_addr;
            // commit to the same slot on this edge is missed by the read
            r_byp_hit  <= adv1 && s1_we && (r_s1_slot == rd_addr);
            r_byp_data <= s1_wdata;
        end
    end

    t_swrb_slot       cur_slot;
    logic [SEQ_W-1:0] ws_eff;
    logic [SEQ_W:0]   lim_high, lim_depth;
    logic             range_bad, far_high, far_depth, add_reject;
    logic             count_zero;
    logic [CW-1:0]    count_dec;
    t_swrb_out        s1_res;

    always_comb begin
        cur_slot   = r_byp_hit ? r_byp_data : r_rd_data;
        count_zero = (r_count == '0);
        count_dec  = r_count - CW'(1);

        // an add to an empty buffer first moves the window to its number
        ws_eff     = count_zero ? r_s1.sequence_req : r_ws;
        lim_high   = {1'b0, ws_eff} + (SEQ_W+1)'(r_high_mark);
        lim_depth  = {1'b0, ws_eff} + (SEQ_W+1)'(DEPTH);
        range_bad  = (r_s1.sequence_req > r_max_seq) || (r_s1.sequence_req < ws_eff);
        far_high   = {1'b0, r_s1.sequence_req} >= lim_high;
        far_depth  = {1'b0, r_s1.sequence_req} >= lim_depth;
        add_reject = range_bad || (far_high && far_depth);

        n_ws       = r_ws;
        n_ws_slot  = r_ws_slot;
        n_count    = r_count;
        s1_we      = 1'b0;
        s1_wdata   = '{full: 1'b0, word: '0};
        s1_res     = '{success: 1'b0, out_word: '0, high_water: 1'b0, low_water: 1'b0};

        case (r_s1.operation)
            OP_ADD: begin
                n_ws              = ws_eff;
                n_ws_slot         = count_zero ? r_s1_slot : r_ws_slot;
                s1_res.high_water = !range_bad && far_high;
                if (!add_reject && !cur_slot.full) begin
                    s1_we          = 1'b1;
                    s1_wdata       = '{full: 1'b1, word: r_s1.payload};
                    n_count        = r_count + CW'(1);
                    s1_res.success = 1'b1;
                end
            end
            OP_NEXT: begin
                if (count_zero) begin
                    // empty: report low water, window stays
                    s1_res.low_water = 1'b1;
                end else begin
                    n_ws = r_ws + SEQ_W'(1);
                    // the window start slot wraps to zero after the last slot or the largest number
                    if (r_ws == SEQ_MAX || r_ws_slot == LAST_SLOT) begin
                        n_ws_slot = '0;
                    end else begin
                        n_ws_slot = r_ws_slot + AW'(1);
                    end
                    if (cur_slot.full) begin
                        s1_we            = 1'b1;
                        n_count          = count_dec;
                        s1_res.success   = 1'b1;
                        s1_res.out_word  = cur_slot.word;
                        s1_res.low_water = CMPW'(count_dec) < CMPW'(r_low_mark);
                    end
                    // a hole moves the window and returns nothing
                end
            end
            default: ;
        endcase
    end

    // write port shared between clearing pass and commit
    always_comb begin
        if (r_clearing) begin
            mem_we    = 1'b1;
            mem_waddr = r_clear_idx;
            mem_wdata = '{full: 1'b0, word: '0};
        end else begin
            mem_we    = adv1 && s1_we;
            mem_waddr = r_s1_slot;
            mem_wdata = s1_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws      <= '0;
            r_ws_slot <= '0;
            r_count   <= '0;
        end else if (adv1) begin
            r_ws      <= n_ws;
            r_ws_slot <= n_ws_slot;
            r_count   <= n_count;
        end
    end

    // ------------------------------------------------------------------
    // valid flags and output register
    // ------------------------------------------------------------------
    t_swrb_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_s0_valid <= 1'b1;
            end else if (adv0) begin
                r_s0_valid <= 1'b0;
            end
            if (adv0) begin
                r_s1_valid <= 1'b1;
            end else if (adv1) begin
                r_s1_valid <= 1'b0;
            end
            if (adv1) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_out <= s1_res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTH
    // never more entries than slots
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count above depth");

    // the pipeline stays empty while the slots are being cleared
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> (!r_s0_valid && !r_s1_valid))
        else $error("item in flight during clearing pass");

    // a stalled commit stage leaves the window untouched
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |=> ($stable(r_ws) && $stable(r_count)))
        else $error("window state moved while commit stalled");

    // a returned word removes exactly one entry
    a_next_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv1 && r_s1.operation == OP_NEXT && s1_res.success)
        |=> (r_count == $past(r_count) - CW'(1)))
        else $error("entry count not decremented by next");
`endif

endmodule

`default_nettype wire

// ===== tb/sliding_window_reorder_buffer_tb.sv =====
// self-checking testbench for the sliding window reorder buffer: a directed table, then
// randomised phases under several register settings, checked against a local predictor
// depends on swrb_pkg and sliding_window_reorder_buffer
`timescale 1ns / 1ps

module sliding_window_reorder_buffer_tb;
    import swrb_pkg::*;

    localparam int DEPTH       = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int N_PHASES    = 6;
    localparam int HOLD_PHASE  = 4;   // phase in which the sender waits for a full drain
    localparam int MAX_REPORTS = 10;

    // one row of the directed table; result is used only where known is set
    typedef struct packed {
        t_swrb_in  item;
        logic      known;
        t_swrb_out result;
    } t_dir_row;

    // dut ports
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    t_swrb_in              i_item      = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    t_swrb_out             o_result;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // predictor state: window, occupancy and the register copies
    logic [SEQ_W-1:0]  win_start;
    int unsigned       live_count;
    bit                slot_taken [DEPTH];
    logic [WORD_W-1:0] slot_data [DEPTH];
    logic [SEQ_W-1:0]  cfg_max_seq;
    logic [MARK_W-1:0] cfg_high_mark;
    logic [MARK_W-1:0] cfg_low_mark;

    t_swrb_out   due_results [$];   // results still owed by the dut, oldest first
    t_dir_row    dir_rows [$];
    int          mismatches = 0;
    int          cycles     = 0;
    int          stall_left = 0;
    bit          tx_idle_en = 1'b0;
    bit          rx_idle_en = 1'b0;

    // register settings per random phase; the maximum sequence number takes both its extremes
    int unsigned ph_max [N_PHASES]   = '{32'h7fff_ffff, 32'h7fff_ffff, 0, 1024,
                                         32'h7fff_ffff, 32'h7fff_ffff};
    int unsigned ph_high [N_PHASES]  = '{48, 1, 64, 32, 48, 64};
    int unsigned ph_low [N_PHASES]   = '{16, 0, 64, 8, 16, 1};
    int unsigned ph_items [N_PHASES] = '{200, 250, 150, 300, 300, 450};

    sliding_window_reorder_buffer #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (o_result),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // works out the result of one transfer and moves the window
    function automatic t_swrb_out reorder_predict(t_swrb_in it);
        t_swrb_out       r;
        int unsigned     slot;
        bit              reject;
        longint unsigned seq;
        longint unsigned base;
        r = '0;
        if (it.operation == OP_ADD) begin
            slot   = it.sequence_req % DEPTH;
            reject = 1'b0;
            // an empty buffer re-anchors the window, even for an add that then fails
            if (live_count == 0) win_start = it.sequence_req;
            seq  = it.sequence_req;
            base = win_start;
            // sums are 64 bits wide so a window near the top never wraps here
            if (it.sequence_req > cfg_max_seq || seq < base) begin
                reject = 1'b1;
            end else if (seq >= base + cfg_high_mark) begin
                r.high_water = 1'b1;
                if (seq >= base + DEPTH) reject = 1'b1;
            end
            if (!reject && !slot_taken[slot]) begin
                slot_data[slot]  = it.payload;
                slot_taken[slot] = 1'b1;
                live_count++;
                r.success = 1'b1;
            end
        end else if (live_count == 0) begin
            // next on an empty buffer: window stays put
            r.low_water = 1'b1;
        end else begin
            slot      = win_start % DEPTH;
            win_start = win_start + 1'b1;   // wraps to zero past the top
            if (slot_taken[slot]) begin
                slot_taken[slot] = 1'b0;
                live_count--;
                r.low_water = (live_count < cfg_low_mark);
                r.out_word  = slot_data[slot];
                r.success   = 1'b1;
            end
            // otherwise a hole: the window moves, nothing returned
        end
        return r;
    endfunction

    function automatic void add_row(t_op op, logic [SEQ_W-1:0] seq, logic [WORD_W-1:0] word,
                                    bit known, bit ok, logic [WORD_W-1:0] res_word,
                                    bit hi, bit lo);
        t_dir_row r;
        r.item.operation    = op;
        r.item.sequence_req = seq;
        r.item.payload      = word;
        r.known             = known;
        r.result.success    = ok;
        r.result.out_word   = res_word;
        r.result.high_water = hi;
        r.result.low_water  = lo;
        dir_rows.push_back(r);
    endfunction

    // random item; mostly in or near the window, adds favoured in fill runs and nexts in drain runs
    function automatic t_swrb_in random_item(bit draining);
        t_swrb_in    it;
        int unsigned pick;
        logic [31:0] seq;
        it.payload = $urandom;
        pick = $urandom_range(0, 15);
        if (pick == 0) it.payload = '0;
        else if (pick == 1) it.payload = '1;
        pick = $urandom_range(0, 99);
        if (live_count == 0) begin
            // fresh window: anywhere, near the top of the range, low, or close by
            if (pick < 25)      seq = $urandom;
            else if (pick < 50) seq = SEQ_MAX - $urandom_range(0, 80);
            else if (pick < 80) seq = $urandom_range(0, 1100);
            else                seq = win_start + $urandom_range(0, 80);
        end else if (pick < 80) begin
            seq = win_start + $urandom_range(0, DEPTH + 8);
        end else if (pick < 90) begin
            seq = win_start - $urandom_range(1, 8);   // behind the window
        end else begin
            seq = $urandom;
        end
        it.sequence_req = seq[SEQ_W-1:0];
        it.operation = ($urandom_range(0, 99) < (draining ? 75 : 35)) ? OP_NEXT : OP_ADD;
        return it;
    endfunction

    // presents one item, waits for its transfer, then books the expected result
    task automatic send_item(t_swrb_in it, bit known, t_swrb_out typed);
        t_swrb_out predicted;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        predicted = reorder_predict(it);
        due_results.push_back(known ? typed : predicted);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic check_result(t_swrb_out got);
        t_swrb_out want;
        if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("unexpected result transfer: ok=%0b word=%h hi=%0b lo=%0b",
                         got.success, got.out_word, got.high_water, got.low_water);
        end else begin
            want = due_results.pop_front();
            if (got.success !== want.success || got.out_word !== want.out_word ||
                got.high_water !== want.high_water || got.low_water !== want.low_water) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: exp ok=%0b word=%h hi=%0b lo=%0b, got ok=%0b word=%h hi=%0b lo=%0b",
                             want.success, want.out_word, want.high_water, want.low_water,
                             got.success, got.out_word, got.high_water, got.low_water);
            end
        end
    endtask

    // result side: check each transfer, stall in random bursts
    always @(posedge i_clk) begin
        if (o_valid === 1'b1 && i_stall === 1'b0) check_result(o_result);
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 4);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        t_swrb_in it;
        int       run_left;
        bit       draining;
        run_left = 0;
        draining = 1'b0;

        // predictor starts from the reset state
        win_start     = '0;
        live_count    = 0;
        cfg_max_seq   = MAX_SEQ_RESET;
        cfg_high_mark = HIGH_MARK_RESET;
        cfg_low_mark  = LOW_MARK_RESET;
        foreach (slot_taken[k]) slot_taken[k] = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n    <= 1'b1;
        tx_idle_en = 1'b1;
        rx_idle_en <= 1'b1;
        // the clearing pass holds o_stall high; the first transfer simply waits for it

        // directed table under the reset register values
        // next on an empty buffer, fields all ones and ignored
        add_row(OP_NEXT, SEQ_MAX, '1, 1, 0, '0, 0, 1);
        // top sequence number anchors the window, then duplicate and behind-window adds
        add_row(OP_ADD, SEQ_MAX, 32'hffff_ffff, 1, 1, '0, 0, 0);
        add_row(OP_ADD, SEQ_MAX, 32'h0000_0000, 1, 0, '0, 0, 0);
        add_row(OP_ADD, '0, 32'h5a5a_5a5a, 1, 0, '0, 0, 0);
        // take it out: window start wraps to zero, buffer below the low mark
        add_row(OP_NEXT, '0, '0, 1, 1, 32'hffff_ffff, 0, 1);
        add_row(OP_NEXT, SEQ_MAX, '1, 1, 0, '0, 0, 1);
        // window at zero: just under, at and past the high mark, then a full window ahead
        add_row(OP_ADD, 31'd0, 32'h0000_0000, 1, 1, '0, 0, 0);
        add_row(OP_ADD, 31'd47, 32'ha5a5_a5a5, 1, 1, '0, 0, 0);
        add_row(OP_ADD, 31'd48, 32'hc3c3_c3c3, 1, 1, '0, 1, 0);
        add_row(OP_ADD, 31'd63, 32'h3c3c_3c3c, 1, 1, '0, 1, 0);
        add_row(OP_ADD, 31'd64, 32'h1111_1111, 1, 0, '0, 1, 0);
        add_row(OP_ADD, 31'd1000, 32'h2222_2222, 1, 0, '0, 1, 0);
        // word back, then a hole, then an add that has fallen behind
        add_row(OP_NEXT, '0, '0, 1, 1, 32'h0000_0000, 0, 1);
        add_row(OP_NEXT, '0, '0, 1, 0, '0, 0, 0);
        add_row(OP_ADD, 31'd1, 32'h3333_3333, 1, 0, '0, 0, 0);
        // slot index wraps inside the window
        add_row(OP_ADD, 31'd65, 32'hf0f0_f0f0, 1, 1, '0, 1, 0);
        // the rest goes to the predictor
        add_row(OP_ADD, 31'd2, 32'h1234_5678, 0, 0, '0, 0, 0);
        add_row(OP_ADD, 31'd3, 32'h8000_0001, 0, 0, '0, 0, 0);
        add_row(OP_NEXT, '0, '0, 0, 0, '0, 0, 0);
        add_row(OP_NEXT, '0, '0, 0, 0, '0, 0, 0);
        add_row(OP_NEXT, '0, '0, 0, 0, '0, 0, 0);
        add_row(OP_ADD, SEQ_MAX - 31'd1, 32'hdead_beef, 0, 0, '0, 0, 0);

        foreach (dir_rows[k]) send_item(dir_rows[k].item, dir_rows[k].known, dir_rows[k].result);

        for (int p = 0; p < N_PHASES; p++) begin
            // registers change only with nothing in flight
            i_valid <= 1'b0;
            while (due_results.size() != 0) @(posedge i_clk);
            write_reg(CFG_MAX_SEQUENCE, ph_max[p][CFG_DATA_W-1:0]);
            write_reg(CFG_HIGH_MARK, ph_high[p][CFG_DATA_W-1:0]);
            write_reg(CFG_LOW_MARK, ph_low[p][CFG_DATA_W-1:0]);
            i_cfg_wr_en   <= 1'b0;
            cfg_max_seq   = ph_max[p][SEQ_W-1:0];
            cfg_high_mark = ph_high[p][MARK_W-1:0];
            cfg_low_mark  = ph_low[p][MARK_W-1:0];

            // last phase runs flat out on both sides
            tx_idle_en = (p != N_PHASES - 1);
            rx_idle_en <= (p != N_PHASES - 1);

            for (int n = 0; n < ph_items[p]; n++) begin
                if (p == HOLD_PHASE && n == ph_items[p] / 2) begin
                    // sender holds off until every owed result has come back
                    i_valid <= 1'b0;
                    while (due_results.size() != 0) @(posedge i_clk);
                end
                if (run_left == 0) begin
                    draining = ~draining;
                    run_left = $urandom_range(20, 60);
                end
                run_left--;
                it = random_item(draining);
                send_item(it, 1'b0, '0);
            end
        end

        i_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        // keep clocking to catch stray result transfers
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
